[design/hbp_pkg.sv]
// Shared types and constants for the Huffman bit packer.
`default_nettype none

package hbp_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int ACC_W  = 39;
  localparam int LEFT_W = 7;
  localparam int S_DATA_W = 48;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic ST_DATA  = 1'b0;
  localparam logic ST_NOSYM = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic   flush;
    logic   hit;
    entry_t entry;
  } lookup_t;

endpackage

`default_nettype wire

[design/huffman_bit_packer.sv]
// Top level of the Huffman bit packer: code table memory, lookup stage and packer.
`default_nettype none

// Each input word carries an operation in s_tuser: load a code table entry, encode a
// symbol, or flush the partial byte. Loads write the table and give no output. An
// encode or flush passes through the registered table lookup and then occupies the
// packer until the last of its k bytes (0 to 4) is sent, as the single output byte
// register holds one byte at a time; so a long code holds off the next item, and short
// codes are taken one per cycle while the output is not stalled. Encoding a symbol
// with no table entry gives one word with status set and tlast high. The table needs
// no clearing pass: its valid bits clear at reset.
module huffman_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [hbp_pkg::S_DATA_W-1:0]  s_tdata,  // symbol, code_bits, code_length
  input  wire logic [1:0]                    s_tuser,  // operation
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,  // out_byte
  output logic [0:0]                         m_tuser,  // status
  output logic                               m_tlast
);
  import hbp_pkg::*;

  localparam int DEPTH   = 1 << SYMBOL_WIDTH;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  entry_t mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;

  logic [SYMBOL_WIDTH-1:0] idx;
  logic [CODE_W-1:0]       code_in;
  logic [LEN_W-1:0]        len_in;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W-1:0]       code_masked;
  entry_t                  wr_entry;

  logic    accept;
  logic    wr_en;
  logic    rd_en;
  logic    a_valid;
  logic    a_flush;
  logic    a_hit;
  entry_t  rd_entry;
  lookup_t lookup;
  logic    take;

  assign idx     = s_tdata[SYMBOL_WIDTH-1:0];
  assign code_in = s_tdata[8 +: CODE_W];
  assign len_in  = s_tdata[8 + CODE_W +: LEN_W];
  assign len_sat = (len_in > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_in;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_masked[i] = code_in[i] && (LEN_W'(i) < len_sat);
    end
  end

  assign wr_entry = '{len: len_sat, code: code_masked};

  assign s_tready = !a_valid || take;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (s_tuser == OP_LOAD);
  assign rd_en    = accept && ((s_tuser == OP_ENCODE) || (s_tuser == OP_FLUSH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      a_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[idx] <= 1'b1;
      end
      if (rd_en) begin
        a_valid <= 1'b1;
      end else if (take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_flush <= (s_tuser == OP_FLUSH);
      a_hit   <= entry_valid[idx];
    end
  end

  assign lookup = '{flush: a_flush, hit: a_hit, entry: rd_entry};

  hbp_packer u_packer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .lookup   (lookup),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[design/hbp_packer.sv]
// Bit accumulator that merges looked-up codes and shifts out one byte per cycle while the output is not stalled.
`default_nettype none

module hbp_packer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire hbp_pkg::lookup_t lookup,
  output logic                 take,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,  // out_byte
  output logic [0:0]           m_tuser,  // status
  output logic                 m_tlast
);
  import hbp_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [LEN_W-1:0] cnt;
  logic             spec;
  logic             spec_err;

  logic [ACC_W-1:0] acc_next;
  logic [LEN_W-1:0] cnt_next;
  logic             spec_next;
  logic             spec_err_next;

  logic             pend;
  logic             out_free;
  logic             emit;
  logic             is_last;
  logic [7:0]       emit_byte;
  logic [7:0]       flush_src;
  logic [ACC_W-1:0] base_acc;
  logic [LEN_W-1:0] base_cnt;
  logic [LEFT_W-1:0] lo_bits;

  assign pend     = spec || (cnt >= LEN_W'(8));
  assign out_free = !m_tvalid || m_tready;
  assign emit     = pend && out_free;
  assign is_last  = spec || (cnt < LEN_W'(16));
  assign take     = in_valid && (!pend || (emit && is_last));
  assign flush_src = {1'b0, acc[LEFT_W-1:0]};

  always_comb begin
    if (spec && spec_err) begin
      emit_byte = 8'd0;
    end else if (spec) begin
      emit_byte = flush_src << (3'(4'd8 - {1'b0, cnt[2:0]}));
    end else begin
      emit_byte = 8'(acc >> (cnt - LEN_W'(8)));
    end
  end

  always_comb begin
    base_acc = acc;
    base_cnt = cnt;
    if (emit) begin
      if (spec && !spec_err) begin
        base_acc = '0;
        base_cnt = '0;
      end else if (!spec) begin
        base_cnt = cnt - LEN_W'(8);
      end
    end
    for (int i = 0; i < LEFT_W; i++) begin
      lo_bits[i] = base_acc[i] && (LEN_W'(i) < base_cnt);
    end
  end

  always_comb begin
    acc_next      = base_acc;
    cnt_next      = base_cnt;
    spec_next     = spec && !emit;
    spec_err_next = spec_err;
    if (take) begin
      if (lookup.flush) begin
        if (base_cnt != '0) begin
          spec_next     = 1'b1;
          spec_err_next = 1'b0;
        end
      end else if (!lookup.hit) begin
        spec_next     = 1'b1;
        spec_err_next = 1'b1;
      end else begin
        acc_next = (ACC_W'(lo_bits) << lookup.entry.len) | ACC_W'(lookup.entry.code);
        cnt_next = base_cnt + lookup.entry.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      cnt      <= '0;
      spec     <= 1'b0;
      spec_err <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      acc      <= acc_next;
      cnt      <= cnt_next;
      spec     <= spec_next;
      spec_err <= spec_err_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tuser <= (spec && spec_err) ? ST_NOSYM : ST_DATA;
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the Huffman bit packer: directed table, then random words.
`timescale 1ns / 100ps

module tb_top;
  import hbp_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int SYM_W = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 167;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    logic        typed;
    logic        has_word;
    out_word_t   word;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  huffman_bit_packer #(
    .MAX_CODE_LEN(MAX_LEN),
    .SYMBOL_WIDTH(SYM_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Mirror of the packer state.
  logic [31:0] code_mem [256];
  logic [5:0]  len_mem [256];
  logic        entry_ok [256];
  logic [6:0]  pend_bits = '0;
  int          pend_cnt = 0;

  out_word_t   packed_bytes[$];
  out_word_t   expected_bytes[$];
  logic [7:0]  known_syms[$];
  out_word_t   got_word;
  out_word_t   want_word;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 54;

  stim_row_t directed_rows [25] = '{
    '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1, '{8'h00, ST_NOSYM, 1'b1}},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
    '{OP_UNUSED, 8'hA5, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, '0},
    '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_LOAD,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, '0},
    '{OP_LOAD,   8'h01, 32'h0000_0005, 6'd63, 1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_LOAD,   8'h02, 32'h0000_0005, 6'd3,  1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1, '{8'hA0, ST_DATA, 1'b1}},
    '{OP_LOAD,   8'h03, 32'hFFFF_FF01, 6'd5,  1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_LOAD,   8'h04, 32'h0000_0000, 6'd33, 1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_LOAD,   8'h02, 32'h0000_007F, 6'd7,  1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b1, 1'b1, '{8'h00, ST_NOSYM, 1'b1}},
    '{OP_LOAD,   8'h80, 32'h0000_0001, 6'd1,  1'b1, 1'b0, '0},
    '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1, '{8'h80, ST_DATA, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (entry_ok[i]) entry_ok[i] = 1'b0;
  end

  // Fills packed_bytes with the words that one accepted input causes.
  function automatic void pack_symbol(input logic [1:0] op, input logic [7:0] sym,
                                      input logic [31:0] code, input logic [5:0] len);
    logic [63:0] acc;
    int          clen;
    int          total;
    int          nbytes;
    packed_bytes.delete();
    case (op)
      OP_LOAD: begin
        code_mem[sym] = code;
        len_mem[sym] = (len > MAX_LEN) ? 6'(MAX_LEN) : len;
        entry_ok[sym] = 1'b1;
      end
      OP_ENCODE: begin
        if (!entry_ok[sym]) begin
          packed_bytes.push_back('{8'h00, ST_NOSYM, 1'b1});
        end else begin
          clen = len_mem[sym];
          acc = (64'(pend_bits) << clen) | (64'(code_mem[sym]) & ((64'd1 << clen) - 64'd1));
          total = pend_cnt + clen;
          nbytes = total / 8;
          for (int k = 0; k < nbytes; k++) begin
            total = total - 8;
            packed_bytes.push_back('{8'(acc >> total), ST_DATA, k == nbytes - 1});
          end
          pend_cnt = total;
          pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
        end
      end
      OP_FLUSH: begin
        if (pend_cnt != 0) begin
          packed_bytes.push_back('{8'(16'(pend_bits) << (8 - pend_cnt)), ST_DATA, 1'b1});
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, len, code, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    int          pick;
    int          lpick;
    pick = $urandom_range(99);
    sym = 8'($urandom_range(255));
    code = $urandom;
    len = 6'($urandom_range(63));
    if (pick < 15) begin
      op = OP_LOAD;
      lpick = $urandom_range(99);
      if (lpick < 60) len = 6'($urandom_range(8, 1));
      else if (lpick < 80) len = 6'($urandom_range(16, 9));
      else if (lpick < 88) len = 6'($urandom_range(32, 17));
      else if (lpick < 94) len = 6'd0;
      else len = 6'($urandom_range(63, 33));
      known_syms.push_back(sym);
    end else if (pick < 80) begin
      op = OP_ENCODE;
      if (known_syms.size() != 0 && $urandom_range(99) < 88)
        sym = known_syms[$urandom_range(known_syms.size() - 1)];
    end else if (pick < 93) begin
      op = OP_FLUSH;
    end else begin
      op = OP_UNUSED;
    end
    send_word(op, sym, code, len);
    pack_symbol(op, sym, code, len);
    foreach (packed_bytes[i]) expected_bytes.push_back(packed_bytes[i]);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word = '{m_tdata, m_tuser[0], m_tlast};
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: byte %02h status %0d last %0d",
                   got_word.out_byte, got_word.status, got_word.last);
      end else begin
        want_word = expected_bytes.pop_front();
        if (got_word.out_byte !== want_word.out_byte || got_word.status !== want_word.status
            || got_word.last !== want_word.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Word mismatch: expected byte %02h status %0d last %0d, got %02h %0d %0d",
                     want_word.out_byte, want_word.status, want_word.last,
                     got_word.out_byte, got_word.status, got_word.last);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].code,
                directed_rows[i].len);
      pack_symbol(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].code,
                  directed_rows[i].len);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_word) expected_bytes.push_back(directed_rows[i].word);
      end else begin
        foreach (packed_bytes[j]) expected_bytes.push_back(packed_bytes[j]);
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) send_random_word();
    end
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/hbp_pkg.sv
design/hbp_packer.sv
design/huffman_bit_packer.sv
verif/tb_top.sv
